### rtl/nps_pkg.sv
// Shared types and constants for the nearest point search block.
package nps_pkg;

	localparam int BANK_W = 6;
	localparam int OP_W   = 2;
	localparam int DSQ_W  = 26;
	localparam int DIST_W = 13;

	localparam logic [DSQ_W-1:0]  DSQ_MAX    = {DSQ_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
	localparam logic [DSQ_W-1:0]  STOP_RESET = 26'd246;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DEC  = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

endpackage

### rtl/nps_ifs.sv
// Channel interfaces: request items, result items and the config write channel.
interface nps_req_if #(parameter int COORD_BITS = 12);
	import nps_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [OP_W-1:0]              operation;
	logic [BANK_W-1:0]            bank;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;

	modport source (output valid, operation, bank, pos_x, pos_y, pos_z, input ready);
	modport sink   (input valid, operation, bank, pos_x, pos_y, pos_z, output ready);
endinterface

interface nps_rsp_if #(parameter int IDX_W = 9, parameter int CNT_W = 10);
	import nps_pkg::*;
	logic              valid;
	logic              ready;
	logic              found;
	logic [IDX_W-1:0]  nearest_index;
	logic [DSQ_W-1:0]  distance_sq;
	logic [DIST_W-1:0] distance;
	logic              append_full;
	logic [CNT_W-1:0]  stored_count;

	modport source (output valid, found, nearest_index, distance_sq, distance, append_full,
		stored_count, input ready);
	modport sink   (input valid, found, nearest_index, distance_sq, distance, append_full,
		stored_count, output ready);
endinterface

interface nps_cfg_if;
	import nps_pkg::*;
	logic             valid;
	logic             ready;
	logic [DSQ_W-1:0] stop_dist_sq;

	modport source (output valid, stop_dist_sq, input ready);
	modport sink   (input valid, stop_dist_sq, output ready);
endinterface

### rtl/nps_isqrt.sv
// Iterative floor square root, one root bit per cycle.
module nps_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [nps_pkg::DSQ_W-1:0] operand,
	output logic                      done,
	output logic [nps_pkg::DIST_W-1:0] root
);
	import nps_pkg::*;

	localparam int REM_W  = DIST_W + 3;
	localparam int STEP_W = $clog2(DIST_W);

	logic [DSQ_W-1:0]  val_q;
	logic [REM_W-1:0]  rem_q;
	logic [DIST_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             ge;

	// remainder stays below 2*root+1, so its top two bits are always free
	assign rem_sh = {rem_q[REM_W-3:0], val_q[DSQ_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_W'(DIST_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIST_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[DSQ_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[DIST_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/nps_scan.sv
// Point memory with append write port and the pipelined distance scan of one bank.
module nps_scan #(
	parameter int NUM_BANKS       = 36,
	parameter int POINTS_PER_BANK = 512,
	parameter int COORD_BITS      = 12,
	parameter int AW              = 15,
	parameter int IDX_W           = 9,
	parameter int CNT_W           = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [AW-1:0]             base,
	input  logic [CNT_W-1:0]          count,
	input  logic [COORD_BITS-1:0]     qx,
	input  logic [COORD_BITS-1:0]     qy,
	input  logic [COORD_BITS-1:0]     qz,
	input  logic [nps_pkg::DSQ_W-1:0] stop_sq,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [3*COORD_BITS-1:0]   wr_data,
	output logic                      done,
	output logic                      found,
	output logic [IDX_W-1:0]          best_idx,
	output logic [nps_pkg::DSQ_W-1:0] best_dsq
);
	import nps_pkg::*;

	localparam int DEPTH = NUM_BANKS * POINTS_PER_BANK;
	localparam int CB    = COORD_BITS;
	localparam int SQ_W  = 2 * CB;
	localparam int SUM_W = 2 * CB + 2;
	localparam int CMP_W = (SUM_W > DSQ_W) ? SUM_W : DSQ_W;

	logic [3*CB-1:0] mem [DEPTH];

	logic              busy_q;
	logic              hit_q;
	logic              found_q;
	logic [CNT_W-1:0]  issue_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [AW-1:0]     base_q;
	logic [CB-1:0]     qx_q, qy_q, qz_q;
	logic [DSQ_W-1:0]  stop_q;
	logic [SUM_W-1:0]  best_q;
	logic [IDX_W-1:0]  idx_q;

	logic [3*CB-1:0]   rd_s1;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [SQ_W-1:0]   sqx_s2, sqy_s2, sqz_s2;
	logic              vld_s2;
	logic [IDX_W-1:0]  idx_s2;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic signed [CB:0]    dx, dy, dz;
	logic signed [2*CB+1:0] px, py, pz;
	logic [SUM_W-1:0]      sum;
	logic                  take;
	logic                  fin;
	logic [CMP_W-1:0]      best_ext;

	assign rd_en   = busy_q && !hit_q && (issue_q < cnt_q);
	assign rd_addr = base_q + AW'(issue_q[IDX_W-1:0]);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_s1 <= mem[rd_addr];
	end

	// stage 1: differences and squares
	always_comb begin
		dx = $signed({rd_s1[CB-1], rd_s1[CB-1:0]}) - $signed({qx_q[CB-1], qx_q});
		dy = $signed({rd_s1[2*CB-1], rd_s1[2*CB-1:CB]}) - $signed({qy_q[CB-1], qy_q});
		dz = $signed({rd_s1[3*CB-1], rd_s1[3*CB-1:2*CB]}) - $signed({qz_q[CB-1], qz_q});
		px = dx * dx;
		py = dy * dy;
		pz = dz * dz;
	end

	always_ff @(posedge clk) begin
		sqx_s2 <= px[SQ_W-1:0];
		sqy_s2 <= py[SQ_W-1:0];
		sqz_s2 <= pz[SQ_W-1:0];
		idx_s2 <= idx_s1;
		if (rd_en)
			idx_s1 <= issue_q[IDX_W-1:0];
	end

	// stage 2: sum and strict compare; earliest point wins a tie
	assign sum  = SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
	assign take = busy_q && vld_s2 && !hit_q && (!found_q || sum < best_q);
	assign fin  = busy_q && (hit_q || (issue_q == cnt_q && !vld_s1 && !vld_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			hit_q   <= 1'b0;
			found_q <= 1'b0;
			issue_q <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1 && busy_q;
			if (start) begin
				busy_q  <= 1'b1;
				hit_q   <= 1'b0;
				found_q <= 1'b0;
				issue_q <= '0;
			end else begin
				if (rd_en)
					issue_q <= issue_q + 1'b1;
				if (take) begin
					found_q <= 1'b1;
					if (CMP_W'(sum) < CMP_W'(stop_q))
						hit_q <= 1'b1;
				end
				if (fin)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q  <= count;
			base_q <= base;
			qx_q   <= qx;
			qy_q   <= qy;
			qz_q   <= qz;
			stop_q <= stop_sq;
		end
		if (take) begin
			best_q <= sum;
			idx_q  <= idx_s2;
		end
	end

	assign best_ext = CMP_W'(best_q);
	assign best_dsq = (best_ext > CMP_W'(DSQ_MAX)) ? DSQ_MAX : best_ext[DSQ_W-1:0];
	assign done     = fin;
	assign found    = found_q;
	assign best_idx = idx_q;

endmodule

### rtl/nearest_point_search.sv
// Nearest point search top level: count memory, sequencer and result register.
// Channels: req carries one item (operation, bank, pos_x/y/z); rsp returns one
// result item per request; cfg writes stop_dist_sq (reset value 246). The user
// writes it only while idle; the block does not enforce this. Clear and append
// pass through the decode and output states to the result register; other
// operations on the count do the same. A query on a non-empty bank reads the
// stored points: the point memory has one read port, so one stored point is
// read per cycle, followed by the distance pipeline, end detection and a
// bit-serial square root. The scan ends early once the best squared distance
// drops below stop_dist_sq. A query on an empty or out-of-range bank has no scan.
// One item is in work at a time; req is ready in the idle state, so a new item
// is taken at the earliest in the cycle after the result register loads, and the
// next item may be accepted while the previous result waits in the rsp
// register. When rsp stalls, a finished result waits until the register frees.
// Reset (arst_n low) empties every bank at once through per-bank valid bits
// and restores stop_dist_sq; point memory contents are left as they are.
module nearest_point_search #(
	parameter int NUM_BANKS       = 36,
	parameter int POINTS_PER_BANK = 512,
	parameter int COORD_BITS      = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	nps_req_if.sink   req,
	nps_rsp_if.source rsp,
	nps_cfg_if.sink   cfg
);
	import nps_pkg::*;

	localparam int DEPTH = NUM_BANKS * POINTS_PER_BANK;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W = (POINTS_PER_BANK > 1) ? $clog2(POINTS_PER_BANK) : 1;
	localparam int CNT_W = $clog2(POINTS_PER_BANK + 1);
	localparam int BI_W  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

	state_t st_q;

	logic [DSQ_W-1:0]      stop_q;
	op_t                   op_q;
	logic                  bank_ok_q;
	logic [BI_W-1:0]       bidx_q;
	logic [COORD_BITS-1:0] px_q, py_q, pz_q;

	logic [CNT_W-1:0]     cnt_mem [NUM_BANKS];
	logic [CNT_W-1:0]     cnt_rd_q;
	logic [NUM_BANKS-1:0] cnt_vld_q;

	logic              w_found_q;
	logic [IDX_W-1:0]  w_idx_q;
	logic [DSQ_W-1:0]  w_dsq_q;
	logic [DIST_W-1:0] w_dist_q;
	logic              w_full_q;
	logic [CNT_W-1:0]  w_cnt_q;

	logic              o_vld_q;
	logic              o_found_q;
	logic [IDX_W-1:0]  o_idx_q;
	logic [DSQ_W-1:0]  o_dsq_q;
	logic [DIST_W-1:0] o_dist_q;
	logic              o_full_q;
	logic [CNT_W-1:0]  o_cnt_q;

	logic              acc;
	logic              bank_ok;
	logic [BI_W-1:0]   rd_bidx;
	logic [CNT_W-1:0]  cnt_cur;
	logic              can_add;
	logic              dec;
	logic              do_append;
	logic              scan_go;
	logic              root_go;
	logic [DSQ_W-1:0]  root_arg;
	logic [AW-1:0]     base;
	logic [AW-1:0]     wr_addr;
	logic              out_free;

	logic              scan_done;
	logic              scan_found;
	logic [IDX_W-1:0]  scan_idx;
	logic [DSQ_W-1:0]  scan_dsq;
	logic              root_done;
	logic [DIST_W-1:0] root_val;

	assign req.ready = (st_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign bank_ok   = {1'b0, req.bank} < (BANK_W + 1)'(NUM_BANKS);
	assign rd_bidx   = bank_ok ? req.bank[BI_W-1:0] : '0;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stop_q <= STOP_RESET;
		else if (cfg.valid && cfg.ready)
			stop_q <= cfg.stop_dist_sq;
	end

	// count memory: read at acceptance, written back in the decode cycle
	always_ff @(posedge clk) begin
		if (acc)
			cnt_rd_q <= cnt_mem[rd_bidx];
		if (do_append)
			cnt_mem[bidx_q] <= CNT_W'(cnt_cur + 1'b1);
	end

	assign dec       = (st_q == ST_DEC);
	assign cnt_cur   = (bank_ok_q && cnt_vld_q[bidx_q]) ? cnt_rd_q : '0;
	assign can_add   = bank_ok_q && (cnt_cur < CNT_W'(POINTS_PER_BANK));
	assign do_append = dec && op_q == OP_APPEND && can_add;
	assign scan_go   = dec && op_q == OP_QUERY && cnt_cur != '0;
	assign root_go   = (dec && op_q == OP_QUERY && cnt_cur == '0)
		|| (st_q == ST_SCAN && scan_done);
	assign root_arg  = (st_q == ST_SCAN) ? scan_dsq : DSQ_MAX;
	assign base      = AW'(bidx_q) * AW'(POINTS_PER_BANK);
	assign wr_addr   = base + AW'(cnt_cur[IDX_W-1:0]);
	assign out_free  = !o_vld_q || rsp.ready;

	nps_scan #(
		.NUM_BANKS      (NUM_BANKS),
		.POINTS_PER_BANK(POINTS_PER_BANK),
		.COORD_BITS     (COORD_BITS),
		.AW             (AW),
		.IDX_W          (IDX_W),
		.CNT_W          (CNT_W)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_go),
		.base    (base),
		.count   (cnt_cur),
		.qx      (px_q),
		.qy      (py_q),
		.qz      (pz_q),
		.stop_sq (stop_q),
		.wr_en   (do_append),
		.wr_addr (wr_addr),
		.wr_data ({pz_q, py_q, px_q}),
		.done    (scan_done),
		.found   (scan_found),
		.best_idx(scan_idx),
		.best_dsq(scan_dsq)
	);

	nps_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_go),
		.operand(root_arg),
		.done   (root_done),
		.root   (root_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_vld_q <= '0;
			o_vld_q   <= 1'b0;
		end else begin
			o_vld_q <= (st_q == ST_OUT && out_free) || (o_vld_q && !rsp.ready);
			unique case (st_q)
				ST_IDLE: begin
					if (acc)
						st_q <= ST_DEC;
				end
				ST_DEC: begin
					if (op_q == OP_CLEAR)
						cnt_vld_q <= '0;
					if (do_append)
						cnt_vld_q[bidx_q] <= 1'b1;
					if (op_q != OP_QUERY)
						st_q <= ST_OUT;
					else if (scan_go)
						st_q <= ST_SCAN;
					else
						st_q <= ST_ROOT;
				end
				ST_SCAN: begin
					if (scan_done)
						st_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done)
						st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q      <= op_t'(req.operation);
			bank_ok_q <= bank_ok;
			bidx_q    <= rd_bidx;
			px_q      <= req.pos_x;
			py_q      <= req.pos_y;
			pz_q      <= req.pos_z;
		end
		if (dec) begin
			w_found_q <= 1'b0;
			w_idx_q   <= '0;
			w_dsq_q   <= (op_q == OP_QUERY) ? DSQ_MAX : '0;
			w_dist_q  <= '0;
			w_full_q  <= (op_q == OP_APPEND) && !can_add;
			priority if (op_q == OP_CLEAR)
				w_cnt_q <= '0;
			else if (do_append)
				w_cnt_q <= CNT_W'(cnt_cur + 1'b1);
			else
				w_cnt_q <= cnt_cur;
		end
		if (st_q == ST_SCAN && scan_done) begin
			w_found_q <= scan_found;
			w_idx_q   <= scan_idx;
			w_dsq_q   <= scan_dsq;
		end
		if (st_q == ST_ROOT && root_done)
			w_dist_q <= root_val;
		if (st_q == ST_OUT && out_free) begin
			o_found_q <= w_found_q;
			o_idx_q   <= w_idx_q;
			o_dsq_q   <= w_dsq_q;
			o_dist_q  <= w_dist_q;
			o_full_q  <= w_full_q;
			o_cnt_q   <= w_cnt_q;
		end
	end

	assign rsp.valid         = o_vld_q;
	assign rsp.found         = o_found_q;
	assign rsp.nearest_index = o_idx_q;
	assign rsp.distance_sq   = o_dsq_q;
	assign rsp.distance      = o_dist_q;
	assign rsp.append_full   = o_full_q;
	assign rsp.stored_count  = o_cnt_q;

	a_idx_in_bank: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> CNT_W'(rsp.nearest_index) < rsp.stored_count)
		else $error("nearest index beyond bank fill");

	a_sat_root: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.distance_sq == DSQ_MAX |-> rsp.distance == DIST_MAX)
		else $error("saturated distance with wrong root");

	a_full_plain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.append_full |-> !rsp.found && rsp.distance_sq == '0)
		else $error("refused append carries search result");

	a_scan_from_dec: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SCAN |-> $past(st_q) == ST_DEC || $past(st_q) == ST_SCAN)
		else $error("scan entered without decode");

endmodule
